FILE: rtl/slpm_pkg.sv
// Shared types, constants and helpers for the LIKE '%' pattern matcher.
package slpm_pkg;

  localparam int PAT_STORE = 32;               // pattern bytes held in the config registers
  localparam int POS_W     = 6;                // pattern position 0..PAT_STORE
  localparam int IDX_W     = $clog2(PAT_STORE);
  localparam int CHAR_WORDS = 4;
  localparam int CFG_IDX_W = 3;
  localparam logic [7:0] PCT_CHAR = 8'h25;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_0        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_1        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_2        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_3        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT         = 3'd5;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ITEM_MID,
    ITEM_LAST,
    ITEM_EMPTY
  } item_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    item_kind_t kind;
  } item_t;

  // Pattern decode, refreshed every cycle from the config registers.
  typedef struct packed {
    logic [PAT_STORE-1:0][7:0] chars;
    pos_t                      len;
    logic [PAT_STORE:0]        nonpct;    // literal byte inside the pattern, top bit sentinel
    logic [PAT_STORE:0]        stop;      // '%' or past the end, top bit sentinel
    logic [PAT_STORE-1:0]      seg_start; // first byte of a segment
    logic                      anch_start;
    logic                      anch_end;
    logic                      exact;
    logic                      count0;
    logic                      invert;
    pos_t                      first_s;
    pos_t                      first_e;
    logic                      first_streamed;
    pos_t                      fin_s;
    pos_t                      fin_e;
  } pat_info_t;

  // Lowest set position at or above from; PAT_STORE when only the sentinel is left.
  function automatic pos_t find_first(input logic [PAT_STORE:0] vec, input pos_t from);
    pos_t r;
    r = POS_W'(PAT_STORE);
    for (int k = PAT_STORE; k >= 0; k--) begin
      if (vec[k] && (POS_W'(k) >= from)) begin
        r = POS_W'(k);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/slpm_if.sv
// Channel interfaces: subject bytes in, match results out, config writes.
interface slpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       empty_string;
  modport source (output valid, char_code, last_char, empty_string, input ready);
  modport sink   (input valid, char_code, last_char, empty_string, output ready);
endinterface

interface slpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface slpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sql_like_percent_matcher.sv
// Streaming SQL LIKE matcher for '%'-only patterns. Subject bytes enter one per
// transfer on item, one per cycle while the engine runs and result does not stall;
// a string ends with last_char or is a lone empty_string item, and each string
// gives one matched bit on result. The per-byte match is a shift-and bit vector
// over all pattern positions, so the engine takes one byte per clock in its single
// update step while running. A two-entry input queue and an output register let
// either side stall on its own. After reset, and after each config transfer, the
// engine rotates the byte window to rebuild its match vector, then steps to the
// segment a string in progress had reached; bytes are queued meanwhile. Config
// is always accepted.
module sql_like_percent_matcher import slpm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  slpm_in_if.sink    item,
  slpm_out_if.source result,
  slpm_cfg_if.sink   cfg
);

  pat_info_t info;
  logic      wr_d;
  logic      q_valid;
  item_t     q_item;
  logic      q_pop;

  slpm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .info (info),
    .wr_d (wr_d)
  );

  slpm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  slpm_back #(.PATTERN_MAX(PATTERN_MAX), .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .info    (info),
    .wr_d    (wr_d),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_result_from_string_end: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(q_pop && (q_item.kind != ITEM_MID)))
    else $error("result raised without a finished string");

  a_cfg_blocks_engine: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> !q_pop)
    else $error("engine consumed a byte right after a config transfer");

endmodule

FILE: rtl/slpm_cfg.sv
// Config registers and the registered pattern decode derived from them.
module slpm_cfg import slpm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic      clk,
  input  logic      rst,
  slpm_cfg_if.sink  cfg,
  output pat_info_t info,
  output logic      wr_d
);

  localparam int LIM = (PATTERN_MAX < PAT_STORE) ? PATTERN_MAX : PAT_STORE;

  logic [POS_W-1:0]               plen;
  logic [CHAR_WORDS-1:0][63:0]    words;
  logic                           inv;
  pat_info_t                      d;
  logic [PAT_STORE-1:0]           pct_in;
  pos_t                           lm1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= '0;
      words <= '0;
      inv   <= 1'b0;
      wr_d  <= 1'b0;
    end else begin
      wr_d <= cfg.valid;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_PATTERN_LENGTH: plen     <= cfg.data[POS_W-1:0];
          REG_CHARS_0:        words[0] <= cfg.data;
          REG_CHARS_1:        words[1] <= cfg.data;
          REG_CHARS_2:        words[2] <= cfg.data;
          REG_CHARS_3:        words[3] <= cfg.data;
          REG_INVERT:         inv      <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    d        = '0;
    d.chars  = words;
    d.invert = inv;
    d.len    = (plen > POS_W'(LIM)) ? POS_W'(LIM) : plen;
    pct_in   = '0;
    for (int k = 0; k < PAT_STORE; k++) begin
      if (POS_W'(k) < d.len) begin
        d.nonpct[k] = (d.chars[k] != PCT_CHAR);
        d.stop[k]   = (d.chars[k] == PCT_CHAR);
        pct_in[k]   = (d.chars[k] == PCT_CHAR);
      end else begin
        d.nonpct[k] = 1'b0;
        d.stop[k]   = 1'b1;
      end
    end
    d.nonpct[PAT_STORE] = 1'b1;
    d.stop[PAT_STORE]   = 1'b1;
    d.seg_start = d.nonpct[PAT_STORE-1:0] & ~{d.nonpct[PAT_STORE-2:0], 1'b0};
    lm1          = d.len - 1'b1;
    d.anch_start = d.nonpct[0];
    d.anch_end   = (d.len != '0) && d.nonpct[lm1];
    d.exact      = (d.len != '0) && !(|pct_in);
    d.count0     = !(|d.nonpct[PAT_STORE-1:0]);
    d.fin_s      = '0;
    for (int k = 0; k < PAT_STORE; k++) begin
      if (pct_in[k]) begin
        d.fin_s = POS_W'(k + 1);
      end
    end
    d.fin_e          = d.len;
    d.first_s        = find_first(d.nonpct, '0);
    d.first_e        = find_first(d.stop, d.first_s);
    d.first_streamed = (d.first_s < d.len) && ((d.first_e < d.len) || d.exact);
  end

  always_ff @(posedge clk) begin
    info <= d;
  end

endmodule

FILE: rtl/slpm_front.sv
// Input side: classifies each subject byte and holds it in a two-entry queue.
module slpm_front import slpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  slpm_in_if.sink  item,
  output logic     q_valid,
  output item_t    q_item,
  input  logic     q_pop
);

  localparam logic [1:0] DEPTH = 2'd2;

  item_t      ents [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.char_code = item.char_code;
    if (item.empty_string) begin
      cls.kind = ITEM_EMPTY;
    end else if (item.last_char) begin
      cls.kind = ITEM_LAST;
    end else begin
      cls.kind = ITEM_MID;
    end
  end

  assign item.ready = (count != DEPTH);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_item     = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr] <= cls;
    end
  end

endmodule

FILE: rtl/slpm_back.sv
// Match engine: bit-parallel segment tracking per byte, result register on the output.
module slpm_back import slpm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  pat_info_t  info,
  input  logic       wr_d,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  slpm_out_if.source result
);

  localparam int CW    = (LENGTH_BITS > POS_W) ? LENGTH_BITS : POS_W;
  localparam int ROT_W = $clog2(PATTERN_MAX + 1);

  typedef logic [LENGTH_BITS-1:0] cnt_t;
  typedef enum logic [1:0] {ST_SETTLE, ST_REPLAY, ST_WALK, ST_RUN} state_t;

  localparam cnt_t CNT_MAX = {LENGTH_BITS{1'b1}};

  state_t               st;
  logic [7:0]           win [PATTERN_MAX];
  logic [PAT_STORE-1:0] hit;
  pos_t                 segnum;
  pos_t                 walk_cnt;
  logic [ROT_W-1:0]     rot_cnt;
  pos_t                 cur_s;
  pos_t                 cur_e;
  cnt_t                 cs;
  cnt_t                 sc;
  logic                 failed;
  logic                 out_valid;
  logic                 matched;

  logic                 cur_streamed;
  logic                 nxt_streamed;
  pos_t                 nxt_s;
  pos_t                 nxt_e;
  pos_t                 seg_len;
  pos_t                 fin_len;
  pos_t                 epos;
  pos_t                 fpos;
  logic [PAT_STORE-1:0] hit_n;
  cnt_t                 sc_n;
  cnt_t                 cs_inc;
  cnt_t                 cs_n;
  logic                 adv;
  logic                 fail;
  logic                 failed_n;
  logic                 streamed_n;
  logic                 mcur;
  logic                 mfin;
  logic                 ok_consume;
  logic                 ok_empty;
  logic                 res_bit;

  // Shift-and step: bit k set when the newest bytes spell the segment up to position k.
  function automatic logic [PAT_STORE-1:0] hit_step(input pat_info_t pi,
                                                   input logic [PAT_STORE-1:0] h,
                                                   input logic [7:0] c);
    logic [PAT_STORE-1:0] r;
    logic [PAT_STORE-1:0] sh;
    sh = {h[PAT_STORE-2:0], 1'b0};
    for (int k = 0; k < PAT_STORE; k++) begin
      r[k] = pi.nonpct[k] && (pi.chars[k] == c) && (pi.seg_start[k] || sh[k]);
    end
    return r;
  endfunction

  always_comb begin
    cur_streamed = (cur_s < info.len) && ((cur_e < info.len) || info.exact);
    nxt_s        = find_first(info.nonpct, cur_e);
    nxt_e        = find_first(info.stop, nxt_s);
    nxt_streamed = (nxt_s < info.len) && ((nxt_e < info.len) || info.exact);
    seg_len      = cur_e - cur_s;
    fin_len      = info.fin_e - info.fin_s;
    hit_n        = hit_step(info, hit, q_item.char_code);
    epos         = cur_e - 1'b1;
    fpos         = info.fin_e - 1'b1;
    mcur         = hit_n[epos[IDX_W-1:0]];
    mfin         = hit_n[fpos[IDX_W-1:0]];
    sc_n         = (sc == CNT_MAX) ? sc : sc + 1'b1;
    cs_inc       = (cs == CNT_MAX) ? cs : cs + 1'b1;

    adv  = 1'b0;
    fail = 1'b0;
    if (!failed && cur_streamed) begin
      if ((segnum == '0) && info.anch_start) begin
        // anchored prefix is judged once, when the string reaches its length
        if (CW'(sc_n) == CW'(seg_len)) begin
          adv  = mcur;
          fail = !mcur;
        end
      end else if ((CW'(cs_inc) >= CW'(seg_len)) && mcur) begin
        adv = 1'b1;
      end
    end
    cs_n       = adv ? '0 : cs_inc;
    failed_n   = failed || fail;
    streamed_n = adv ? nxt_streamed : cur_streamed;

    ok_consume = info.count0 ||
                 (!failed_n && !streamed_n &&
                  (info.exact ? (cs_n == '0)
                              : (!info.anch_end ||
                                 ((CW'(cs_n) >= CW'(fin_len)) && mfin))));
    ok_empty   = info.count0 || (!info.first_streamed && !info.anch_end);
    res_bit    = ((q_item.kind == ITEM_EMPTY) ? ok_empty : ok_consume) ^ info.invert;
  end

  assign q_pop = q_valid && (st == ST_RUN) && !wr_d &&
                 ((q_item.kind == ITEM_MID) || !out_valid || result.ready);

  assign result.valid   = out_valid;
  assign result.matched = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_SETTLE;
      segnum    <= '0;
      walk_cnt  <= '0;
      rot_cnt   <= '0;
      cs        <= '0;
      sc        <= '0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a finished string loads the result register, else a transfer empties it
      if (q_pop && (q_item.kind != ITEM_MID)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (wr_d) begin
        st <= ST_SETTLE;
      end else begin
        unique case (st)
          ST_SETTLE: begin
            hit     <= '0;
            rot_cnt <= '0;
            st      <= ST_REPLAY;
          end
          // rotate the window once round, rebuilding the hit vector for the new pattern
          ST_REPLAY: begin
            if (rot_cnt == ROT_W'(PATTERN_MAX)) begin
              cur_s    <= info.first_s;
              cur_e    <= info.first_e;
              walk_cnt <= '0;
              st       <= ST_WALK;
            end else begin
              for (int i = 1; i < PATTERN_MAX; i++) begin
                win[i] <= win[i-1];
              end
              win[0]  <= win[PATTERN_MAX-1];
              hit     <= hit_step(info, hit, win[PATTERN_MAX-1]);
              rot_cnt <= rot_cnt + 1'b1;
            end
          end
          // step to the segment the string in progress is waiting on
          ST_WALK: begin
            if (walk_cnt == segnum) begin
              st <= ST_RUN;
            end else begin
              cur_s    <= nxt_s;
              cur_e    <= nxt_e;
              walk_cnt <= walk_cnt + 1'b1;
            end
          end
          ST_RUN: begin
            if (q_pop) begin
              if (q_item.kind != ITEM_EMPTY) begin
                for (int i = 1; i < PATTERN_MAX; i++) begin
                  win[i] <= win[i-1];
                end
                win[0] <= q_item.char_code;
                hit    <= hit_n;
              end
              unique case (q_item.kind)
                ITEM_MID: begin
                  sc     <= sc_n;
                  cs     <= cs_n;
                  failed <= failed_n;
                  if (adv) begin
                    segnum <= segnum + 1'b1;
                    cur_s  <= nxt_s;
                    cur_e  <= nxt_e;
                  end
                end
                ITEM_LAST, ITEM_EMPTY: begin
                  matched   <= res_bit;
                  segnum    <= '0;
                  cur_s     <= info.first_s;
                  cur_e     <= info.first_e;
                  sc        <= '0;
                  cs        <= '0;
                  failed    <= 1'b0;
                end
                default: ;
              endcase
            end
          end
          default: st <= ST_SETTLE;
        endcase
      end
    end
  end

endmodule
